[rtl/core/lpc_pkg.sv]
package lpc_pkg;

    localparam int BG_NUM      = 4;
    localparam int COLOR_W     = 15;
    localparam int CH_W        = 5;
    localparam int CH_NUM      = 3;
    localparam int PRIO_W      = 2;
    localparam int PROD_W      = 9;
    localparam int IN_W        = 89;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 15;

    localparam logic [CH_W-1:0] EV_MAX = 5'd16;
    localparam logic [CH_W-1:0] CH_MAX = 5'd31;

    typedef enum logic [2:0] {
        LT_BG0,
        LT_BG1,
        LT_BG2,
        LT_BG3,
        LT_SPRITE,
        LT_BACKDROP
    } t_layer;

    typedef enum logic [1:0] {
        EFF_NONE,
        EFF_ALPHA,
        EFF_BRIGHT_UP,
        EFF_BRIGHT_DOWN
    } t_effect;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAYER_PRIO,
        REG_LAYER_ENABLE,
        REG_DISPLAY_FLAGS,
        REG_BLEND_TARGETS,
        REG_BLEND_EFFECT,
        REG_ALPHA_COEFFS,
        REG_BRIGHT_COEFF,
        REG_BACKDROP_COLOR
    } t_cfg_reg;

    function automatic logic [CH_W-1:0] clamp_ev(input logic [CH_W-1:0] v);
        return (v > EV_MAX) ? EV_MAX : v;
    endfunction

endpackage

[rtl/core/layer_priority_compositor_top.sv]
// throughput: one pixel per cycle, four register stages (input, layer select,
// per-channel multiply, sum and saturate), stalls back up through all stages
// reset: synchronous active-low, clears the stage valid bits and all
// configuration registers to 0
module layer_priority_compositor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [lpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // bg_colors[59:0], bg_opaque[63:60], sprite_color[78:64], sprite_opaque[79],
    // sprite_priority[81:80], sprite_semi_transparent[82], window_bg_enable[86:83],
    // window_sprite_enable[87], window_blend_enable[88], zero pad
    input  logic [lpc_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // pixel_color[14:0], zero pad
    output logic [lpc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // configuration
    logic [7:0]                    r_layer_prio;
    logic [3:0]                    r_layer_enable;
    logic [1:0]                    r_display_flags;
    logic [11:0]                   r_blend_targets;
    lpc_pkg::t_effect              r_blend_effect;
    logic [9:0]                    r_alpha_coeffs;
    logic [lpc_pkg::CH_W-1:0]      r_bright_coeff;
    logic [lpc_pkg::COLOR_W-1:0]   r_backdrop_color;

    // pipeline control
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    // stage payloads
    logic [lpc_pkg::IN_W-1:0]      r_s1_data;
    logic [lpc_pkg::COLOR_W-1:0]   r_s2_top_c, n_s2_top_c;
    logic [lpc_pkg::COLOR_W-1:0]   r_s2_bot_c, n_s2_bot_c;
    lpc_pkg::t_effect              r_s2_eff, n_s2_eff;
    logic [lpc_pkg::PROD_W-1:0]    r_s3_m0 [lpc_pkg::CH_NUM];
    logic [lpc_pkg::PROD_W-1:0]    n_s3_m0 [lpc_pkg::CH_NUM];
    logic [lpc_pkg::PROD_W-1:0]    r_s3_m1 [lpc_pkg::CH_NUM];
    logic [lpc_pkg::PROD_W-1:0]    n_s3_m1 [lpc_pkg::CH_NUM];
    logic [lpc_pkg::CH_W-1:0]      r_s3_a  [lpc_pkg::CH_NUM];
    lpc_pkg::t_effect              r_s3_eff;
    logic [lpc_pkg::COLOR_W-1:0]   r_s4_color, n_s4_color;

    assign o_cfg_ready = 1'b1;

    assign en4 = !r_v4 || i_m_axis_tready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_s_axis_tready = en1;

    assign o_m_axis_tvalid = r_v4;
    assign o_m_axis_tdata  = {1'b0, r_s4_color};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_prio     <= '0;
            r_layer_enable   <= '0;
            r_display_flags  <= '0;
            r_blend_targets  <= '0;
            r_blend_effect   <= lpc_pkg::EFF_NONE;
            r_alpha_coeffs   <= '0;
            r_bright_coeff   <= '0;
            r_backdrop_color <= '0;
        end else if (i_cfg_valid) begin
            unique case (lpc_pkg::t_cfg_reg'(i_cfg_index))
                lpc_pkg::REG_LAYER_PRIO:     r_layer_prio     <= i_cfg_data[7:0];
                lpc_pkg::REG_LAYER_ENABLE:   r_layer_enable   <= i_cfg_data[3:0];
                lpc_pkg::REG_DISPLAY_FLAGS:  r_display_flags  <= i_cfg_data[1:0];
                lpc_pkg::REG_BLEND_TARGETS:  r_blend_targets  <= i_cfg_data[11:0];
                lpc_pkg::REG_BLEND_EFFECT:
                    r_blend_effect <= lpc_pkg::t_effect'(i_cfg_data[1:0]);
                lpc_pkg::REG_ALPHA_COEFFS:   r_alpha_coeffs   <= i_cfg_data[9:0];
                lpc_pkg::REG_BRIGHT_COEFF:   r_bright_coeff   <= i_cfg_data[4:0];
                lpc_pkg::REG_BACKDROP_COLOR: r_backdrop_color <= i_cfg_data;
            endcase
        end
    end

    // stage 2: layer selection and effect decision
    always_comb begin
        logic [59:0]                 bgc;
        logic [3:0]                  bgo;
        logic [lpc_pkg::COLOR_W-1:0] spc;
        logic                        spo;
        logic [1:0]                  spp;
        logic                        sps;
        logic [3:0]                  wbg;
        logic                        wsp;
        logic                        wbl;
        logic                        win;
        logic [4:0]                  key;
        logic [4:0]                  top_k;
        logic [4:0]                  bot_k;
        lpc_pkg::t_layer             top_t;
        lpc_pkg::t_layer             bot_t;
        logic                        alpha_sprite;
        logic                        dst;
        logic                        src;
        logic [lpc_pkg::COLOR_W-1:0] colors [6];

        bgc = r_s1_data[59:0];
        bgo = r_s1_data[63:60];
        spc = r_s1_data[78:64];
        spo = r_s1_data[79];
        spp = r_s1_data[81:80];
        sps = r_s1_data[82];
        wbg = r_s1_data[86:83];
        wsp = r_s1_data[87];
        wbl = r_s1_data[88];
        win = r_display_flags[1];

        // key is {priority, background number}, backdrop ranks as priority 4
        top_k = {3'd4, 2'd0};
        bot_k = {3'd4, 2'd0};
        top_t = lpc_pkg::LT_BACKDROP;
        bot_t = lpc_pkg::LT_BACKDROP;
        for (int n = 0; n < lpc_pkg::BG_NUM; n++) begin
            key = {1'b0, r_layer_prio[2*n +: 2], 2'(n)};
            if (r_layer_enable[n] && (!win || wbg[n]) && bgo[n]) begin
                if (key < top_k) begin
                    bot_k = top_k;
                    bot_t = top_t;
                    top_k = key;
                    top_t = lpc_pkg::t_layer'(3'(n));
                end else if (key < bot_k) begin
                    bot_k = key;
                    bot_t = lpc_pkg::t_layer'(3'(n));
                end
            end
        end

        // sprite takes only the layer type of the slot it displaces
        alpha_sprite = 1'b0;
        if ((!win || wsp) && r_display_flags[0] && spo) begin
            if ({1'b0, spp} <= top_k[4:2]) begin
                bot_t        = top_t;
                top_t        = lpc_pkg::LT_SPRITE;
                alpha_sprite = sps;
            end else if ({1'b0, spp} <= bot_k[4:2]) begin
                bot_t = lpc_pkg::LT_SPRITE;
            end
        end

        for (int n = 0; n < lpc_pkg::BG_NUM; n++) begin
            colors[n] = bgc[lpc_pkg::COLOR_W*n +: lpc_pkg::COLOR_W];
        end
        colors[4] = spc;
        colors[5] = r_backdrop_color;

        unique case (top_t)
            lpc_pkg::LT_BG0:    n_s2_top_c = colors[0];
            lpc_pkg::LT_BG1:    n_s2_top_c = colors[1];
            lpc_pkg::LT_BG2:    n_s2_top_c = colors[2];
            lpc_pkg::LT_BG3:    n_s2_top_c = colors[3];
            lpc_pkg::LT_SPRITE: n_s2_top_c = colors[4];
            default:            n_s2_top_c = colors[5];
        endcase
        unique case (bot_t)
            lpc_pkg::LT_BG0:    n_s2_bot_c = colors[0];
            lpc_pkg::LT_BG1:    n_s2_bot_c = colors[1];
            lpc_pkg::LT_BG2:    n_s2_bot_c = colors[2];
            lpc_pkg::LT_BG3:    n_s2_bot_c = colors[3];
            lpc_pkg::LT_SPRITE: n_s2_bot_c = colors[4];
            default:            n_s2_bot_c = colors[5];
        endcase

        dst = r_blend_targets[4'(top_t)];
        src = r_blend_targets[4'd6 + 4'(bot_t)];
        n_s2_eff = lpc_pkg::EFF_NONE;
        if (!win || wbl || alpha_sprite) begin
            priority if (alpha_sprite && src) begin
                n_s2_eff = lpc_pkg::EFF_ALPHA;
            end else if (dst && r_blend_effect != lpc_pkg::EFF_NONE &&
                         (src || r_blend_effect != lpc_pkg::EFF_ALPHA)) begin
                n_s2_eff = r_blend_effect;
            end
        end
    end

    // stage 3: per-channel products
    always_comb begin
        logic [lpc_pkg::CH_W-1:0] a;
        logic [lpc_pkg::CH_W-1:0] b;
        logic [lpc_pkg::CH_W-1:0] ea;
        logic [lpc_pkg::CH_W-1:0] eb;
        logic [lpc_pkg::CH_W-1:0] ey;
        logic [9:0]               p0;
        logic [9:0]               p1;

        ea = lpc_pkg::clamp_ev(r_alpha_coeffs[4:0]);
        eb = lpc_pkg::clamp_ev(r_alpha_coeffs[9:5]);
        ey = lpc_pkg::clamp_ev(r_bright_coeff);
        for (int k = 0; k < lpc_pkg::CH_NUM; k++) begin
            a = r_s2_top_c[lpc_pkg::CH_W*k +: lpc_pkg::CH_W];
            b = r_s2_bot_c[lpc_pkg::CH_W*k +: lpc_pkg::CH_W];
            unique case (r_s2_eff)
                lpc_pkg::EFF_ALPHA: begin
                    p0 = 10'(a) * 10'(ea);
                    p1 = 10'(b) * 10'(eb);
                end
                lpc_pkg::EFF_BRIGHT_UP: begin
                    p0 = 10'(lpc_pkg::CH_MAX - a) * 10'(ey);
                    p1 = '0;
                end
                lpc_pkg::EFF_BRIGHT_DOWN: begin
                    p0 = 10'(a) * 10'(ey);
                    p1 = '0;
                end
                default: begin
                    p0 = '0;
                    p1 = '0;
                end
            endcase
            n_s3_m0[k] = p0[lpc_pkg::PROD_W-1:0];
            n_s3_m1[k] = p1[lpc_pkg::PROD_W-1:0];
        end
    end

    // stage 4: sum, shift and saturate (alpha), or add/subtract the shifted product (brightness)
    always_comb begin
        logic [9:0]               sum;
        logic [5:0]               sh;
        logic [lpc_pkg::CH_W-1:0] r;

        n_s4_color = '0;
        for (int k = 0; k < lpc_pkg::CH_NUM; k++) begin
            sum = 10'(r_s3_m0[k]) + 10'(r_s3_m1[k]);
            sh  = sum[9:4];
            unique case (r_s3_eff)
                lpc_pkg::EFF_ALPHA:
                    r = (sh > 6'(lpc_pkg::CH_MAX)) ? lpc_pkg::CH_MAX : sh[4:0];
                lpc_pkg::EFF_BRIGHT_UP:   r = r_s3_a[k] + r_s3_m0[k][8:4];
                lpc_pkg::EFF_BRIGHT_DOWN: r = r_s3_a[k] - r_s3_m0[k][8:4];
                default:                  r = r_s3_a[k];
            endcase
            n_s4_color[lpc_pkg::CH_W*k +: lpc_pkg::CH_W] = r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_data <= i_s_axis_tdata[lpc_pkg::IN_W-1:0];
        end
        if (en2) begin
            r_s2_top_c <= n_s2_top_c;
            r_s2_bot_c <= n_s2_bot_c;
            r_s2_eff   <= n_s2_eff;
        end
        if (en3) begin
            for (int k = 0; k < lpc_pkg::CH_NUM; k++) begin
                r_s3_m0[k] <= n_s3_m0[k];
                r_s3_m1[k] <= n_s3_m1[k];
                r_s3_a[k]  <= r_s2_top_c[lpc_pkg::CH_W*k +: lpc_pkg::CH_W];
            end
            r_s3_eff <= r_s2_eff;
        end
        if (en4) begin
            r_s4_color <= n_s4_color;
        end
    end

endmodule
